// ===== rtl/sre_pkg.sv =====
package sre_pkg;

  localparam int COORD_W    = 16;
  localparam int PRESS_W    = 13;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 28;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] WIDTH_GAIN_RST   = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0] LENGTH_SCALE_RST = GAIN_W'(32768);

  // segment difference, sum of squares, root
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W + 2;
  localparam int ROOT_STEPS = SQ_W / 2;

  // gain * pressure, quotient and offset
  localparam int WP_W  = GAIN_W + PRESS_W;
  localparam int QUO_W = WP_W - GAIN_W + 1;
  localparam int OFS_W = QUO_W + 1;
  localparam int DIV_W = DIFF_W + GAIN_W + QUO_W - 1;

  localparam int UNIT_W  = (SQ_W > DIV_W) ? SQ_W : DIV_W;
  localparam int MUL_A_W = (DIFF_W > GAIN_W) ? DIFF_W : GAIN_W;
  localparam int MUL_B_W = (COORD_W > WP_W) ? COORD_W : WP_W;

  localparam int STEPS_MAX = (ROOT_STEPS > QUO_W) ? ROOT_STEPS : QUO_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);

  localparam int VTX_W     = ((COORD_W > OFS_W) ? COORD_W : OFS_W) + 1;
  localparam int RUN_SUM_W = ((LEN_W > DIFF_W) ? LEN_W : DIFF_W) + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic signed [VTX_W-1:0] VTX_HI =
    VTX_W'((longint'(1) <<< (COORD_W - 1)) - 1);
  localparam logic signed [VTX_W-1:0] VTX_LO =
    VTX_W'(-(longint'(1) <<< (COORD_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_GAIN   = 1'b0,
    REG_LENGTH_SCALE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    UOP_MAC,
    UOP_CSUB
  } unit_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_INC,
    ST_WP,
    ST_NUM_X,
    ST_DIV_X,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_EMIT
  } state_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [VTX_W-1:0] v);
    logic signed [VTX_W-1:0] c;
    c = v;
    if (v > VTX_HI) c = VTX_HI;
    else if (v < VTX_LO) c = VTX_LO;
    return c[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/sre_if.sv =====
interface sre_in_if import sre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic [PRESS_W-1:0]        pressure;
  logic                      stroke_start;

  modport source (output valid, x_pos, y_pos, pressure, stroke_start, input ready);
  modport sink   (input valid, x_pos, y_pos, pressure, stroke_start, output ready);
endinterface

interface sre_out_if import sre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] left_x;
  logic signed [COORD_W-1:0] left_y;
  logic signed [COORD_W-1:0] right_x;
  logic signed [COORD_W-1:0] right_y;
  logic [LEN_W-1:0]          tex_coord;

  modport source (output valid, left_x, left_y, right_x, right_y, tex_coord, input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, tex_coord, output ready);
endinterface

// ===== rtl/sre_unit.sv =====
// Shared arithmetic unit: multiply-add, or compare-and-subtract.
module sre_unit import sre_pkg::*; (
  input  unit_op_t            op,
  input  logic [MUL_A_W-1:0]  mul_a,
  input  logic [MUL_B_W-1:0]  mul_b,
  input  logic [UNIT_W-1:0]   opd_a,
  input  logic [UNIT_W-1:0]   opd_b,
  output logic [UNIT_W-1:0]   res,
  output logic                ge
);

  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [UNIT_W:0]            diff;

  assign prod = mul_a * mul_b;
  assign diff = {1'b0, opd_a} - {1'b0, opd_b};
  assign ge   = ~diff[UNIT_W];

  always_comb begin
    unique case (op)
      UOP_MAC:  res = UNIT_W'(prod) + opd_a;
      UOP_CSUB: res = diff[UNIT_W-1:0];
      default:  res = '0;
    endcase
  end

endmodule

// ===== rtl/stroke_ribbon_expander_core.sv =====
// A segment of nonzero length steps the shared unit through two squares, COORD_W+1 root
//   steps, the length increment, gain * pressure and two QUO_W-step restoring divides
//   (x and y offsets); a zero-length segment skips the divides. A point that emits nothing
//   leaves the block idle; input is ready only while idle, so one segment runs at a time.
// Reset (rst_n, synchronous, active low): idle, no stored point, length zero, registers at
//   width_gain = 6554 and length_scale = 32768, result channel empty.
module stroke_ribbon_expander_core import sre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sre_in_if.sink                in_ch,
  sre_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // sequencer
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  // config
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] scale_r;

  // stroke state
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [PRESS_W-1:0]        prev_p_r;
  logic                      have_prev_r;
  logic [LEN_W-1:0]          run_len_r;

  // per-segment working set
  logic signed [COORD_W-1:0] base_x_r, base_y_r;
  logic [PRESS_W-1:0]        base_p_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic [COORD_W-1:0]        ax_r, ay_r;   // magnitudes, halved when sh_r
  logic                      sh_r;
  logic [DIFF_W-1:0]         len_r;
  logic [WP_W-1:0]           wp_r;
  logic signed [OFS_W-1:0]   ox_r;

  // shared-unit operands: acc = radicand / remainder, aux = root / shifted divisor
  logic [UNIT_W-1:0] acc_r, aux_r;
  logic [SQ_W-1:0]   bit_r;
  logic [QUO_W-1:0]  quo_r;

  // result register
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] left_x_r, left_y_r, right_x_r, right_y_r;
  logic [LEN_W-1:0]          tex_r;

  // unit hookup
  unit_op_t           uop;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [UNIT_W-1:0]  opd_a, opd_b, ures;
  logic               uge;

  sre_unit u_unit (
    .op    (uop),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .opd_a (opd_a),
    .opd_b (opd_b),
    .res   (ures),
    .ge    (uge)
  );

  // ---------------------------------------------------------------------------------------
  // Input side: difference to the stored point, done in the transfer cycle.
  logic                     in_xfer;
  logic                     seg_go;
  logic signed [DIFF_W-1:0] dx_in, dy_in;
  logic [DIFF_W-1:0]        mx_in, my_in;
  logic                     half_in;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign seg_go      = in_xfer && !in_ch.stroke_start && have_prev_r;

  assign dx_in = DIFF_W'(in_ch.x_pos) - DIFF_W'(prev_x_r);
  assign dy_in = DIFF_W'(in_ch.y_pos) - DIFF_W'(prev_y_r);
  assign mx_in = dx_in[DIFF_W-1] ? DIFF_W'(-dx_in) : DIFF_W'(dx_in);
  assign my_in = dy_in[DIFF_W-1] ? DIFF_W'(-dy_in) : DIFF_W'(dy_in);
  // differences of 2^31 or more are halved for the root only (wide coordinates)
  assign half_in = ((mx_in >> 31) != '0) || ((my_in >> 31) != '0);

  // ---------------------------------------------------------------------------------------
  // Derived values used by several states.
  logic [DIFF_W-1:0]       abs_dx, abs_dy;
  logic [DIFF_W-1:0]       len_now;
  logic [DIFF_W-1:0]       inc;
  logic [RUN_SUM_W-1:0]    run_sum;
  logic signed [OFS_W-1:0] quo_s;
  logic signed [OFS_W-1:0] ox_now, oy_now;
  logic                    dy_pos;
  logic                    emit_go;

  assign abs_dx  = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign abs_dy  = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
  assign len_now = aux_r[DIFF_W-1:0] << sh_r;
  // (len * scale + half) >> 16
  assign inc     = ures[GAIN_W +: DIFF_W];
  assign run_sum = RUN_SUM_W'(run_len_r) + RUN_SUM_W'(inc);
  assign quo_s   = $signed({1'b0, quo_r});
  assign dy_pos  = !dy_r[DIFF_W-1] && (dy_r != '0);
  // x offset follows -dy, y offset follows dx
  assign ox_now  = dy_pos ? -quo_s : quo_s;
  assign oy_now  = (len_r == '0) ? '0 : (dx_r[DIFF_W-1] ? -quo_s : quo_s);
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state and unit operand select.
  always_comb begin
    state_nxt = state_r;
    uop       = UOP_MAC;
    mul_a     = '0;
    mul_b     = '0;
    opd_a     = '0;
    opd_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (seg_go) state_nxt = ST_SQ_X;
      end
      ST_SQ_X: begin
        mul_a     = MUL_A_W'(ax_r);
        mul_b     = MUL_B_W'(ax_r);
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        mul_a     = MUL_A_W'(ay_r);
        mul_b     = MUL_B_W'(ay_r);
        opd_a     = acc_r;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        // bit-pair root: trial value is root | bit, no carries
        uop   = UOP_CSUB;
        opd_a = acc_r;
        opd_b = aux_r | UNIT_W'(bit_r);
        if (cnt_r == '0) state_nxt = ST_INC;
      end
      ST_INC: begin
        mul_a     = MUL_A_W'(len_now);
        mul_b     = MUL_B_W'(scale_r);
        opd_a     = UNIT_W'(1) << (GAIN_W - 1);
        state_nxt = ST_WP;
      end
      ST_WP: begin
        mul_a     = MUL_A_W'(gain_r);
        mul_b     = MUL_B_W'(base_p_r);
        state_nxt = (len_r == '0) ? ST_EMIT : ST_NUM_X;
      end
      ST_NUM_X: begin
        // |n| * wp + den / 2, den = len << 16
        mul_a     = MUL_A_W'(abs_dy);
        mul_b     = MUL_B_W'(wp_r);
        opd_a     = UNIT_W'(len_r) << (GAIN_W - 1);
        state_nxt = ST_DIV_X;
      end
      ST_DIV_X: begin
        uop   = UOP_CSUB;
        opd_a = acc_r;
        opd_b = aux_r;
        if (cnt_r == '0) state_nxt = ST_NUM_Y;
      end
      ST_NUM_Y: begin
        mul_a     = MUL_A_W'(abs_dx);
        mul_b     = MUL_B_W'(wp_r);
        opd_a     = UNIT_W'(len_r) << (GAIN_W - 1);
        state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        uop   = UOP_CSUB;
        opd_a = acc_r;
        opd_b = aux_r;
        if (cnt_r == '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------------------
  // Control state: config, stored point, running length, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= WIDTH_GAIN_RST;
      scale_r     <= LENGTH_SCALE_RST;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_p_r    <= '0;
      have_prev_r <= 1'b0;
      run_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_WIDTH_GAIN:   gain_r  <= GAIN_W'(cfg_wdata);
          REG_LENGTH_SCALE: scale_r <= GAIN_W'(cfg_wdata);
          default: ;
        endcase
      end

      if (in_xfer) begin
        prev_x_r    <= in_ch.x_pos;
        prev_y_r    <= in_ch.y_pos;
        prev_p_r    <= in_ch.pressure;
        have_prev_r <= 1'b1;
        if (in_ch.stroke_start) run_len_r <= '0;
      end

      if (state_r == ST_INC) begin
        run_len_r <= (run_sum > RUN_SUM_W'(LEN_MAX)) ? LEN_MAX : run_sum[LEN_W-1:0];
      end

      if (emit_go)           out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (seg_go) begin
          base_x_r <= prev_x_r;
          base_y_r <= prev_y_r;
          base_p_r <= prev_p_r;
          dx_r     <= dx_in;
          dy_r     <= dy_in;
          sh_r     <= half_in;
          ax_r     <= COORD_W'(half_in ? (mx_in >> 1) : mx_in);
          ay_r     <= COORD_W'(half_in ? (my_in >> 1) : my_in);
        end
      end
      ST_SQ_X: acc_r <= ures;
      ST_SQ_Y: begin
        acc_r <= ures;
        aux_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        cnt_r <= CNT_W'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        if (uge) begin
          acc_r <= ures;
          aux_r <= (aux_r >> 1) | UNIT_W'(bit_r);
        end else begin
          aux_r <= aux_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      ST_INC: len_r <= len_now;
      ST_WP: begin
        wp_r <= ures[WP_W-1:0];
        ox_r <= '0;
        quo_r <= '0;
      end
      ST_NUM_X, ST_NUM_Y: begin
        acc_r <= ures;
        aux_r <= UNIT_W'(len_r) << (GAIN_W + QUO_W - 1);
        quo_r <= '0;
        cnt_r <= CNT_W'(QUO_W - 1);
        if (state_r == ST_NUM_Y) ox_r <= ox_now;
      end
      ST_DIV_X, ST_DIV_Y: begin
        if (uge) acc_r <= ures;
        quo_r <= {quo_r[QUO_W-2:0], uge};
        aux_r <= aux_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          left_x_r  <= sat_coord(VTX_W'(base_x_r) - VTX_W'(ox_r));
          left_y_r  <= sat_coord(VTX_W'(base_y_r) - VTX_W'(oy_now));
          right_x_r <= sat_coord(VTX_W'(base_x_r) + VTX_W'(ox_r));
          right_y_r <= sat_coord(VTX_W'(base_y_r) + VTX_W'(oy_now));
          tex_r     <= run_len_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_x    = left_x_r;
  assign out_ch.left_y    = left_y_r;
  assign out_ch.right_x   = right_x_r;
  assign out_ch.right_y   = right_y_r;
  assign out_ch.tex_coord = tex_r;

endmodule

// ===== verif/tb_stroke_ribbon_expander_core.sv =====
module tb_stroke_ribbon_expander_core;
  import sre_pkg::*;

  // Run shape
  localparam int PHASE_ITEMS   = 160;      // random points per register setting
  localparam int DIAG_SEGMENTS = 120;      // max-size segments at full gain and scale
  localparam int SETTLE_CYCLES = 64;       // settling wait before register writes and the final check
  localparam int MAX_WAIT      = 6;        // longest per-item gap or stall
  localparam int CYCLE_LIMIT   = 1000000;  // several times the slowest legal run

  // Length math only halves differences once they reach this magnitude
  localparam longint unsigned HALVE_AT = 64'h8000_0000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PRESS_W-1:0]        p;
    logic                      start;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic [LEN_W-1:0]          tex;
  } vertex_pair_t;

  // Tracks the ribbon geometry the block should produce and checks each
  // vertex pair that comes out against the oldest one it has worked out.
  class ribbon_predictor;
    longint unsigned gain;
    longint unsigned scale;
    longint          prev_x;
    longint          prev_y;
    longint unsigned prev_p;
    longint unsigned run_len;
    bit              have_prev;
    vertex_pair_t    pending_pairs[$];
    int              errors;

    function new();
      gain      = WIDTH_GAIN_RST;
      scale     = LENGTH_SCALE_RST;
      prev_x    = 0;
      prev_y    = 0;
      prev_p    = 0;
      run_len   = 0;
      have_prev = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WIDTH_GAIN:   gain  = val;
        REG_LENGTH_SCALE: scale = val;
        default: ;
      endcase
    endfunction

    // floor(sqrt(v)), bit by bit from the top; v < 2^63 so the root fits 32 bits
    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // n * wp / den, rounded half away from zero
    static function longint round_offset(longint n, longint unsigned wp,
                                         longint unsigned den);
      longint unsigned an;
      longint unsigned q;
      an = (n < 0) ? -n : n;
      q  = (an * wp + den / 2) / den;
      return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    static function logic signed [COORD_W-1:0] clip_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      else if (v < lo) v = lo;
      return COORD_W'(v);
    endfunction

    function void note_point(point_t pt);
      longint          dx;
      longint          dy;
      longint          ox;
      longint          oy;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned len;
      longint unsigned inc;
      longint unsigned wp;
      int              sh;
      vertex_pair_t    vp;
      if (pt.start) begin
        run_len = 0;
      end else if (have_prev) begin
        dx = longint'(pt.x) - prev_x;
        dy = longint'(pt.y) - prev_y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sh = 0;
        while (ax >= HALVE_AT || ay >= HALVE_AT) begin
          ax >>= 1;
          ay >>= 1;
          sh++;
        end
        len = floor_root(ax * ax + ay * ay) << sh;
        inc = (len * scale + 64'd32768) >> 16;
        run_len += inc;
        if (run_len > LEN_MAX) run_len = LEN_MAX;
        ox = 0;
        oy = 0;
        if (len != 0) begin
          wp = gain * prev_p;
          ox = round_offset(-dy, wp, len << 16);
          oy = round_offset(dx, wp, len << 16);
        end
        vp.lx  = clip_coord(prev_x - ox);
        vp.ly  = clip_coord(prev_y - oy);
        vp.rx  = clip_coord(prev_x + ox);
        vp.ry  = clip_coord(prev_y + oy);
        vp.tex = run_len[LEN_W-1:0];
        pending_pairs.insert(pending_pairs.size(), vp);
      end
      prev_x    = pt.x;
      prev_y    = pt.y;
      prev_p    = pt.p;
      have_prev = 1'b1;
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("mismatch %0d: %s", errors, msg);
    endtask

    task check_pair(vertex_pair_t got);
      vertex_pair_t want;
      if (pending_pairs.size() == 0) begin
        flag_mismatch("vertex pair arrived with none pending");
        return;
      end
      want = pending_pairs.pop_front();
      if (got.lx !== want.lx)
        flag_mismatch($sformatf("left_x got %0d want %0d", got.lx, want.lx));
      if (got.ly !== want.ly)
        flag_mismatch($sformatf("left_y got %0d want %0d", got.ly, want.ly));
      if (got.rx !== want.rx)
        flag_mismatch($sformatf("right_x got %0d want %0d", got.rx, want.rx));
      if (got.ry !== want.ry)
        flag_mismatch($sformatf("right_y got %0d want %0d", got.ry, want.ry));
      if (got.tex !== want.tex)
        flag_mismatch($sformatf("tex_coord got %0d want %0d", got.tex, want.tex));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sre_in_if  in_ch ();
  sre_out_if out_ch ();

  stroke_ribbon_expander_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ribbon_predictor ribbon;
  bit              no_idle;   // set for stretches where neither side waits
  int unsigned     cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** stroke_ribbon_expander_core: FAILED **");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic point_t mk_point(int x, int y, int p, bit s);
    point_t pt;
    pt.x     = COORD_W'(x);
    pt.y     = COORD_W'(y);
    pt.p     = PRESS_W'(p);
    pt.start = s;
    return pt;
  endfunction

  // Mostly in the nominal 0..1.0 range; now and then the full 13 bits,
  // which the block takes unclamped.
  function automatic int rand_pressure();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 8191);
    return $urandom_range(0, 4096);
  endfunction

  // One point per transfer. valid is only dropped when a gap follows, so a
  // back-to-back point never sees a low/high pair in the same step.
  task automatic send_point(point_t pt);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.x_pos        <= pt.x;
    in_ch.y_pos        <= pt.y;
    in_ch.pressure     <= pt.p;
    in_ch.stroke_start <= pt.start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ribbon.note_point(pt);
  endtask

  // Sender holds off until every pending vertex pair has been seen.
  // Always waits on a clock edge before checking, so a following valid drop is a new step.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (ribbon.pending_pairs.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    ribbon.set_reg(idx, val);
  endtask

  // Registers must only move while the block is idle; the block does not enforce it.
  // A start or first point gives no pair, so also wait SETTLE_CYCLES after the last one.
  task automatic apply_setting(logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] scale);
    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_WIDTH_GAIN, gain);
    write_reg(REG_LENGTH_SCALE, scale);
  endtask

  // Strokes with random walks: zero-length steps, small, medium and axis-aligned moves, the
  // odd jump anywhere in the plane. Noise: some strokes skip the start flag,
  // some carry a stray start mid-stroke.
  task automatic random_strokes(int unsigned count);
    int unsigned sent;
    int unsigned seg_cnt;
    int unsigned mode;
    int          cx;
    int          cy;
    sent = 0;
    while (sent < count) begin
      no_idle = ($urandom_range(0, 6) == 0);
      seg_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      send_point(mk_point(cx, cy, rand_pressure(), $urandom_range(0, 9) != 0));
      sent++;
      for (int k = 0; k < seg_cnt && sent < count; k++) begin
        mode = $urandom_range(0, 9);
        case (mode)
          0: ;
          1, 2, 3, 4: begin
            cx = clamp_coord(cx + $signed($urandom_range(0, 128)) - 64);
            cy = clamp_coord(cy + $signed($urandom_range(0, 128)) - 64);
          end
          5, 6, 7: begin
            cx = clamp_coord(cx + $signed($urandom_range(0, 8192)) - 4096);
            cy = clamp_coord(cy + $signed($urandom_range(0, 8192)) - 4096);
          end
          8: begin
            // axis-aligned move: one normal component is exactly zero
            if ($urandom_range(0, 1)) cx = clamp_coord(cx + $signed($urandom_range(0, 65534)) - 32767);
            else cy = clamp_coord(cy + $signed($urandom_range(0, 65534)) - 32767);
          end
          default: begin
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
          end
        endcase
        send_point(mk_point(cx, cy, rand_pressure(), $urandom_range(0, 15) == 0));
        sent++;
        if ($urandom_range(0, 199) == 0) quiesce();
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall before each pair, ready held until it comes.
  initial begin : pair_sink
    int unsigned  stall;
    vertex_pair_t got;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.lx  = out_ch.left_x;
      got.ly  = out_ch.left_y;
      got.rx  = out_ch.right_x;
      got.ry  = out_ch.right_y;
      got.tex = out_ch.tex_coord;
      ribbon.check_pair(got);
    end
  end

  initial begin : stimulus
    ribbon  = new();
    no_idle = 1'b0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.x_pos        <= '0;
    in_ch.y_pos        <= '0;
    in_ch.pressure     <= '0;
    in_ch.stroke_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_WIDTH_GAIN;
    cfg_wdata          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at reset register values.
    // First point with no start flag: stored, nothing emitted.
    send_point(mk_point(100, 200, 4096, 1'b0));
    send_point(mk_point(300, 200, 2048, 1'b0));
    send_point(mk_point(300, -200, 4096, 1'b0));
    // Stroke start clears the length, then a zero-length segment.
    send_point(mk_point(0, 0, 4096, 1'b1));
    send_point(mk_point(0, 0, 1000, 1'b0));
    // Corner to corner: largest differences, vertex saturation.
    send_point(mk_point(32767, 32767, 8191, 1'b0));
    send_point(mk_point(-32768, -32768, 0, 1'b0));
    send_point(mk_point(32767, -32768, 4096, 1'b0));
    send_point(mk_point(-32768, 32767, 8191, 1'b0));
    send_point(mk_point(32767, 32767, 8191, 1'b0));
    // Back-to-back starts, then a zero-length segment at minimum x.
    send_point(mk_point(-32768, 0, 8191, 1'b1));
    send_point(mk_point(-32768, 0, 8191, 1'b1));
    send_point(mk_point(-32768, 0, 8191, 1'b0));
    // One-LSB move, pressure above 1.0 then zero.
    send_point(mk_point(-32767, 1, 5000, 1'b0));
    send_point(mk_point(-32767, 2, 0, 1'b0));
    send_point(mk_point(0, 0, 0, 1'b0));
    // Pure axis moves, then a new stroke with one corner-to-corner segment.
    send_point(mk_point(4096, 0, 4096, 1'b0));
    send_point(mk_point(4096, 4096, 4096, 1'b0));
    send_point(mk_point(32767, -32768, 0, 1'b1));
    send_point(mk_point(-32768, 32767, 8191, 1'b0));

    // Zero gain and scale: ribbon collapses, length stays put.
    apply_setting(16'd0, 16'd0);
    random_strokes(PHASE_ITEMS);

    // Full gain and scale; one long corner-to-corner stroke with the
    // largest length increments, back to back.
    apply_setting(16'hFFFF, 16'hFFFF);
    no_idle = 1'b1;
    send_point(mk_point(32767, 32767, 8191, 1'b1));
    for (int i = 0; i < DIAG_SEGMENTS; i++) begin
      if (i[0]) send_point(mk_point(32767, 32767, rand_pressure(), 1'b0));
      else send_point(mk_point(-32768, -32768, rand_pressure(), 1'b0));
    end
    no_idle = 1'b0;
    random_strokes(PHASE_ITEMS);

    apply_setting(WIDTH_GAIN_RST, LENGTH_SCALE_RST);
    random_strokes(PHASE_ITEMS);

    apply_setting(16'hFFFF, 16'd1);
    random_strokes(PHASE_ITEMS);

    for (int ph = 0; ph < 2; ph++) begin
      apply_setting(CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 65535)));
      random_strokes(PHASE_ITEMS);
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ribbon.errors == 0 && ribbon.pending_pairs.size() == 0) begin
      $display("** stroke_ribbon_expander_core: PASSED **");
    end else begin
      $display("** stroke_ribbon_expander_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sre_pkg.sv
rtl/sre_if.sv
rtl/sre_unit.sv
rtl/stroke_ribbon_expander_core.sv
verif/tb_stroke_ribbon_expander_core.sv
